### rtl/core/sbnfhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnfhc_pkg: shared types and constants of the frame header checker
// Word types on both channels, the record from parser to evaluator,
// configuration register indexes and frame header offsets.
// ----------------------------------------------------------------------------
package sbnfhc_pkg;

  // Frame layout, in bytes
  localparam int FL_SIZE = 16;
  localparam int PD_SIZE = 16;
  localparam int PS_SIZE = 36;
  localparam int SUM_BYTES = FL_SIZE - 2;
  localparam int DATA_OFF_SHORT = FL_SIZE + PD_SIZE;
  localparam int DATA_OFF_LONG  = FL_SIZE + PD_SIZE + PS_SIZE;

  // Byte positions of the decoded fields
  localparam int POS_COMMAND  = 4;
  localparam int POS_STREAM   = 5;
  localparam int POS_FSEQ_LO  = 8;
  localparam int POS_FSEQ_HI  = 11;
  localparam int POS_CSUM_LO  = 14;
  localparam int POS_CSUM_HI  = 15;
  localparam int POS_TTYPE    = 17;
  localparam int POS_BLOCK_LO = 20;
  localparam int POS_BLOCK_HI = 21;
  localparam int POS_CTRL_LO  = 22;
  localparam int POS_CTRL_HI  = 23;
  localparam int POS_SIZE_LO  = 24;
  localparam int POS_SIZE_HI  = 25;
  localparam int POS_PSEQ_LO  = 28;
  localparam int POS_PSEQ_HI  = 31;

  // Width of the length comparison: frame length and offset plus data size
  localparam int LEN_W = 17;

  // Configuration register indexes
  localparam logic [1:0] CFG_DT_CMD   = 2'd0;
  localparam logic [1:0] CFG_COMP_MSK = 2'd1;
  localparam logic [1:0] CFG_CCB_LEN  = 2'd2;
  localparam logic [1:0] CFG_WMO_MIN  = 2'd3;

  // Configuration reset values
  localparam logic [7:0] RST_DT_CMD   = 8'd3;
  localparam logic [7:0] RST_COMP_MSK = 8'd2;
  localparam logic [7:0] RST_CCB_LEN  = 8'd24;
  localparam logic [7:0] RST_WMO_MIN  = 8'd18;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_transfer_command;
    logic [7:0] compressed_mask;
    logic [7:0] ccb_length;
    logic [7:0] wmo_min_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic [7:0]  data_stream;
    logic [31:0] frame_sequence;
    logic [15:0] block_index;
    logic [15:0] ctrl_length;
    logic [15:0] payload_length;
    logic [31:0] product_sequence;
    logic        is_compressed;
    logic        has_ccb;
    logic        needs_inflate;
    logic        has_spec_header;
  } out_word_t;

  // Everything the evaluator needs about one finished frame
  typedef struct packed {
    logic        sum_match;
    logic        too_long;
    logic        short_fl;
    logic        short_pd;
    logic        short_ps;
    logic        len_match;
    logic [7:0]  command;
    logic [7:0]  stream;
    logic [31:0] frame_seq;
    logic [7:0]  xfer_kind;
    logic [15:0] block_index;
    logic [15:0] ctrl_length;
    logic [15:0] payload_length;
    logic [31:0] product_seq;
    logic [7:0]  first_data;
  } frame_rec_t;

endpackage

### rtl/core/sbnfhc_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnfhc_parse: byte parser
// Counts bytes, sums the frame header, captures the header fields and
// pushes one frame record into the queue on the final byte.
// ----------------------------------------------------------------------------
module sbnfhc_parse
  import sbnfhc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       rec_push,
  input  logic       rec_ready,
  output frame_rec_t rec_data
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 2);

  logic [PW-1:0] pos_r, pos_nxt, n_upd;
  logic [15:0]   sum_r, sum_nxt, sum_upd;
  logic [15:0]   csum_r, csum_nxt, csum_upd;
  logic [7:0]    cmd_r, cmd_nxt, cmd_upd;
  logic [7:0]    strm_r, strm_nxt, strm_upd;
  logic [31:0]   fseq_r, fseq_nxt, fseq_upd;
  logic [7:0]    ttype_r, ttype_nxt, ttype_upd;
  logic [15:0]   blk_r, blk_nxt, blk_upd;
  logic [15:0]   ctl_r, ctl_nxt, ctl_upd;
  logic [15:0]   dbs_r, dbs_nxt, dbs_upd;
  logic [31:0]   pseq_r, pseq_nxt, pseq_upd;
  logic [7:0]    fdb_r, fdb_nxt, fdb_upd;
  logic [LEN_W-1:0] data_off;
  logic          accept;
  logic [7:0]    b;

  assign in_ready = rec_ready;
  assign accept   = in_valid && in_ready;
  assign rec_push = accept && in_data.last_byte;
  assign b        = in_data.data_byte;

  // Fold the current word into the frame state
  always_comb begin
    sum_upd   = sum_r;
    csum_upd  = csum_r;
    cmd_upd   = cmd_r;
    strm_upd  = strm_r;
    fseq_upd  = fseq_r;
    ttype_upd = ttype_r;
    blk_upd   = blk_r;
    ctl_upd   = ctl_r;
    dbs_upd   = dbs_r;
    pseq_upd  = pseq_r;
    fdb_upd   = fdb_r;
    if (pos_r < PW'(SUM_BYTES)) begin
      sum_upd = sum_r + {8'd0, b};
    end
    if (pos_r == PW'(POS_COMMAND)) begin
      cmd_upd = b;
    end
    if (pos_r == PW'(POS_STREAM)) begin
      strm_upd = b;
    end
    if (pos_r >= PW'(POS_FSEQ_LO) && pos_r <= PW'(POS_FSEQ_HI)) begin
      fseq_upd = {fseq_r[23:0], b};
    end
    if (pos_r == PW'(POS_CSUM_LO) || pos_r == PW'(POS_CSUM_HI)) begin
      csum_upd = {csum_r[7:0], b};
    end
    if (pos_r == PW'(POS_TTYPE)) begin
      ttype_upd = b;
    end
    if (pos_r == PW'(POS_BLOCK_LO) || pos_r == PW'(POS_BLOCK_HI)) begin
      blk_upd = {blk_r[7:0], b};
    end
    if (pos_r == PW'(POS_CTRL_LO) || pos_r == PW'(POS_CTRL_HI)) begin
      ctl_upd = {ctl_r[7:0], b};
    end
    if (pos_r == PW'(POS_SIZE_LO) || pos_r == PW'(POS_SIZE_HI)) begin
      dbs_upd = {dbs_r[7:0], b};
    end
    if (pos_r >= PW'(POS_PSEQ_LO) && pos_r <= PW'(POS_PSEQ_HI)) begin
      pseq_upd = {pseq_r[23:0], b};
    end
    // First data byte sits after the spec header on block 0
    if (pos_r == ((blk_upd == 16'd0) ? PW'(DATA_OFF_LONG) : PW'(DATA_OFF_SHORT))) begin
      fdb_upd = b;
    end
    // Saturate the byte count one past the frame limit
    n_upd = (pos_r <= PW'(MAX_FRAME_BYTES)) ? pos_r + PW'(1) : pos_r;
  end

  // Build the record for the evaluator
  always_comb begin
    data_off = (blk_upd == 16'd0) ? LEN_W'(DATA_OFF_LONG) : LEN_W'(DATA_OFF_SHORT);
    rec_data.sum_match      = (sum_upd == csum_upd);
    rec_data.too_long       = (n_upd > PW'(MAX_FRAME_BYTES));
    rec_data.short_fl       = (n_upd < PW'(FL_SIZE));
    rec_data.short_pd       = (n_upd < PW'(DATA_OFF_SHORT));
    rec_data.short_ps       = (n_upd < PW'(DATA_OFF_LONG));
    rec_data.len_match      = (LEN_W'(n_upd) == data_off + LEN_W'(dbs_upd));
    rec_data.command        = cmd_upd;
    rec_data.stream         = strm_upd;
    rec_data.frame_seq      = fseq_upd;
    rec_data.xfer_kind      = ttype_upd;
    rec_data.block_index    = blk_upd;
    rec_data.ctrl_length    = ctl_upd;
    rec_data.payload_length = dbs_upd;
    rec_data.product_seq    = pseq_upd;
    rec_data.first_data     = fdb_upd;
  end

  // Advance on each word, clear after the final one
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    csum_nxt  = csum_r;
    cmd_nxt   = cmd_r;
    strm_nxt  = strm_r;
    fseq_nxt  = fseq_r;
    ttype_nxt = ttype_r;
    blk_nxt   = blk_r;
    ctl_nxt   = ctl_r;
    dbs_nxt   = dbs_r;
    pseq_nxt  = pseq_r;
    fdb_nxt   = fdb_r;
    if (accept) begin
      if (in_data.last_byte) begin
        pos_nxt   = '0;
        sum_nxt   = '0;
        csum_nxt  = '0;
        cmd_nxt   = '0;
        strm_nxt  = '0;
        fseq_nxt  = '0;
        ttype_nxt = '0;
        blk_nxt   = '0;
        ctl_nxt   = '0;
        dbs_nxt   = '0;
        pseq_nxt  = '0;
        fdb_nxt   = '0;
      end else begin
        pos_nxt   = n_upd;
        sum_nxt   = sum_upd;
        csum_nxt  = csum_upd;
        cmd_nxt   = cmd_upd;
        strm_nxt  = strm_upd;
        fseq_nxt  = fseq_upd;
        ttype_nxt = ttype_upd;
        blk_nxt   = blk_upd;
        ctl_nxt   = ctl_upd;
        dbs_nxt   = dbs_upd;
        pseq_nxt  = pseq_upd;
        fdb_nxt   = fdb_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      sum_r   <= '0;
      csum_r  <= '0;
      cmd_r   <= '0;
      strm_r  <= '0;
      fseq_r  <= '0;
      ttype_r <= '0;
      blk_r   <= '0;
      ctl_r   <= '0;
      dbs_r   <= '0;
      pseq_r  <= '0;
      fdb_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      csum_r  <= csum_nxt;
      cmd_r   <= cmd_nxt;
      strm_r  <= strm_nxt;
      fseq_r  <= fseq_nxt;
      ttype_r <= ttype_nxt;
      blk_r   <= blk_nxt;
      ctl_r   <= ctl_nxt;
      dbs_r   <= dbs_nxt;
      pseq_r  <= pseq_nxt;
      fdb_r   <= fdb_nxt;
    end
  end

endmodule

### rtl/core/sbnfhc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnfhc_queue: two-entry frame record queue
// Decouples the byte parser from the evaluator so each side stalls alone.
// ----------------------------------------------------------------------------
module sbnfhc_queue
  import sbnfhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       push_ready,
  input  frame_rec_t push_data,
  output logic       pop_valid,
  input  logic       pop,
  output frame_rec_t pop_data
);

  frame_rec_t  entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the record
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/sbnfhc_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnfhc_eval: frame evaluator
// Takes one frame record, decides the status and flags, and holds the
// result word in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module sbnfhc_eval
  import sbnfhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       rec_valid,
  output logic       rec_pop,
  input  frame_rec_t rec,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  out_word_t res;
  logic      dt, pdh_ok, comp, blk0, ctl_nz, letter, ccb, inflate;
  status_t   status;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // Decide status and flags
  always_comb begin
    dt      = (rec.command == cfg.data_transfer_command);
    pdh_ok  = dt && !rec.short_pd;
    comp    = ((rec.xfer_kind & cfg.compressed_mask) != 8'd0);
    blk0    = (rec.block_index == 16'd0);
    ctl_nz  = (rec.ctrl_length != 16'd0);
    letter  = is_letter(rec.first_data);
    ccb     = 1'b0;
    inflate = 1'b0;
    status  = ST_OK;
    priority if (rec.too_long || rec.short_fl) begin
      status = ST_BAD;
    end else if (!rec.sum_match) begin
      status = ST_CSUM;
    end else if (!dt) begin
      status = ST_OK;
    end else if (rec.short_pd || (blk0 && rec.short_ps) || !rec.len_match) begin
      status = ST_BAD;
    end else if (ctl_nz && rec.ctrl_length < {8'd0, cfg.wmo_min_length}) begin
      status = ST_BAD;
    end else if (rec.ctrl_length > rec.payload_length) begin
      status = ST_BAD;
    end else if (!blk0) begin
      status = ST_OK;
    end else if (ctl_nz) begin
      if (!letter) begin
        if (rec.ctrl_length < {8'd0, cfg.ccb_length}) begin
          status = ST_BAD;
        end else begin
          ccb = 1'b1;
        end
      end
    end else if (comp) begin
      inflate = 1'b1;
    end else begin
      if (!letter) begin
        if (rec.payload_length < {8'd0, cfg.ccb_length}) begin
          status = ST_BAD;
        end else begin
          ccb = 1'b1;
        end
      end
    end

    res.status           = status;
    res.command          = rec.command;
    res.data_stream      = rec.stream;
    res.frame_sequence   = rec.frame_seq;
    res.block_index      = pdh_ok ? rec.block_index : 16'd0;
    res.ctrl_length      = pdh_ok ? rec.ctrl_length : 16'd0;
    res.payload_length   = pdh_ok ? rec.payload_length : 16'd0;
    res.product_sequence = pdh_ok ? rec.product_seq : 32'd0;
    res.is_compressed    = pdh_ok && comp;
    res.has_ccb          = ccb;
    res.needs_inflate    = inflate;
    res.has_spec_header  = pdh_ok && blk0 && !rec.short_ps;
  end

  // Load the output register whenever it is free or being emptied
  assign rec_pop = rec_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (rec_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/sbn_frame_header_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbn_frame_header_checker: broadcast frame header checker
// Usage:
//   in_*  : one frame byte per word, last_byte set on the final byte.
//   out_* : one result word per frame (status and decoded header fields).
//   cfg_* : register write port, index 0 data transfer command, 1 compressed
//           mask, 2 CCB length, 3 least WMO control header length. Write
//           only while no frame is in flight.
// Throughput is one byte per cycle while the record queue has room; the byte
// parser updates its counter, running sum and field captures as each byte is
// taken. After the final byte is taken, the result passes through the record
// queue and then into the output register before it appears on out_valid.
// When the receiver stalls, finished frames collect in the two-entry record
// queue and the output register; bytes keep flowing until both are full,
// after which in_ready drops on the next frame's words.
// Reset clears all frame state and loads the default register values.
// ----------------------------------------------------------------------------
module sbn_frame_header_checker
  import sbnfhc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 8192
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t       cfg_r, cfg_nxt;
  logic       push, push_ready, q_valid, q_pop;
  frame_rec_t push_rec, q_rec;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DT_CMD:   cfg_nxt.data_transfer_command = cfg_wdata;
        CFG_COMP_MSK: cfg_nxt.compressed_mask       = cfg_wdata;
        CFG_CCB_LEN:  cfg_nxt.ccb_length            = cfg_wdata;
        CFG_WMO_MIN:  cfg_nxt.wmo_min_length        = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_transfer_command <= RST_DT_CMD;
      cfg_r.compressed_mask       <= RST_COMP_MSK;
      cfg_r.ccb_length            <= RST_CCB_LEN;
      cfg_r.wmo_min_length        <= RST_WMO_MIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sbnfhc_parse #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .rec_push  (push),
    .rec_ready (push_ready),
    .rec_data  (push_rec)
  );

  sbnfhc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_rec),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_rec)
  );

  sbnfhc_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (q_valid),
    .rec_pop   (q_pop),
    .rec       (q_rec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the broadcast frame header checker
// Frames are built byte by byte with correct or broken checksums, lengths,
// control header and CCB sizes, and offered on the input channel with random
// gaps. Every accepted byte runs through a local copy of the header checker,
// which queues the result word expected on each final byte. Result words
// are checked field by field against that queue. Several register settings
// are covered, each written while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
  import sbnfhc_pkg::*;

  localparam int FRAME_MAX    = 8192;
  localparam int RUN_LIMIT    = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_BYTES  = 30;
  localparam int PHASE_FRAMES = 1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_DT_CMD;
  logic [7:0] cfg_wdata = '0;

  sbn_frame_header_checker #(.MAX_FRAME_BYTES(FRAME_MAX)) uut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_word_t  byte_q[$];   // frame words waiting to be offered
  out_word_t want_q[$];   // predicted result words, oldest first
  out_word_t oldest_want;
  cfg_t      cur_cfg = '{RST_DT_CMD, RST_COMP_MSK, RST_CCB_LEN, RST_WMO_MIN};

  // Frame state of the local header checker
  logic [13:0] p_pos = '0;
  logic [15:0] p_sum = '0;
  logic [15:0] p_csum = '0;
  logic [7:0]  p_cmd = '0;
  logic [7:0]  p_stream = '0;
  logic [31:0] p_fseq = '0;
  logic [7:0]  p_ttype = '0;
  logic [15:0] p_block = '0;
  logic [15:0] p_ctrl = '0;
  logic [15:0] p_size = '0;
  logic [31:0] p_pseq = '0;
  logic [7:0]  p_first = '0;

  bit calm = 1'b0;
  int n_errors = 0;
  int n_results = 0;
  int cycles = 0;
  int phase_bytes = 0;
  int phase_frames = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_left = 0;
  int holds_done = 0;

  // Take one frame byte; on the final byte queue the expected result word
  function automatic void predict_byte(input in_word_t w);
    int pos, n, off, dbs, ctl;
    bit dt, pdh_ok, comp, letter, ccb, inflate;
    status_t st;
    out_word_t r;
    pos = int'(p_pos);
    if (pos < SUM_BYTES) p_sum = p_sum + 16'(w.data_byte);
    if (pos == POS_COMMAND) p_cmd = w.data_byte;
    if (pos == POS_STREAM) p_stream = w.data_byte;
    if (pos >= POS_FSEQ_LO && pos <= POS_FSEQ_HI) p_fseq = {p_fseq[23:0], w.data_byte};
    if (pos == POS_CSUM_LO || pos == POS_CSUM_HI) p_csum = {p_csum[7:0], w.data_byte};
    if (pos == POS_TTYPE) p_ttype = w.data_byte;
    if (pos == POS_BLOCK_LO || pos == POS_BLOCK_HI) p_block = {p_block[7:0], w.data_byte};
    if (pos == POS_CTRL_LO || pos == POS_CTRL_HI) p_ctrl = {p_ctrl[7:0], w.data_byte};
    if (pos == POS_SIZE_LO || pos == POS_SIZE_HI) p_size = {p_size[7:0], w.data_byte};
    if (pos >= POS_PSEQ_LO && pos <= POS_PSEQ_HI) p_pseq = {p_pseq[23:0], w.data_byte};
    if (pos == ((p_block == 0) ? DATA_OFF_LONG : DATA_OFF_SHORT)) p_first = w.data_byte;
    // counter saturates one past the longest legal frame
    if (pos <= FRAME_MAX) p_pos = 14'(pos + 1);
    if (!w.last_byte) return;

    n = int'(p_pos);
    dt = (p_cmd == cur_cfg.data_transfer_command);
    pdh_ok = dt && n >= DATA_OFF_SHORT;
    comp = (p_ttype & cur_cfg.compressed_mask) != 0;
    off = (p_block == 0) ? DATA_OFF_LONG : DATA_OFF_SHORT;
    dbs = int'(p_size);
    ctl = int'(p_ctrl);
    letter = (p_first >= 8'h41 && p_first <= 8'h5A) || (p_first >= 8'h61 && p_first <= 8'h7A);
    ccb = 1'b0;
    inflate = 1'b0;
    st = ST_OK;
    if (n > FRAME_MAX || n < FL_SIZE) st = ST_BAD;
    else if (p_sum != p_csum) st = ST_CSUM;
    else if (!dt) st = ST_OK;
    else if (n < DATA_OFF_SHORT || n < off || n != off + dbs) st = ST_BAD;
    else if (ctl != 0 && ctl < cur_cfg.wmo_min_length) st = ST_BAD;
    else if (ctl > dbs) st = ST_BAD;
    else if (p_block != 0) st = ST_OK;
    else if (ctl != 0) begin
      if (!letter) begin
        if (ctl < cur_cfg.ccb_length) st = ST_BAD;
        else ccb = 1'b1;
      end
    end else if (comp) begin
      inflate = 1'b1;
    end else if (!letter) begin
      if (dbs < cur_cfg.ccb_length) st = ST_BAD;
      else ccb = 1'b1;
    end
    if (st != ST_OK) begin
      ccb = 1'b0;
      inflate = 1'b0;
    end

    r.status = st;
    r.command = p_cmd;
    r.data_stream = p_stream;
    r.frame_sequence = p_fseq;
    r.block_index = pdh_ok ? p_block : 16'h0;
    r.ctrl_length = pdh_ok ? p_ctrl : 16'h0;
    r.payload_length = pdh_ok ? p_size : 16'h0;
    r.product_sequence = pdh_ok ? p_pseq : 32'h0;
    r.is_compressed = pdh_ok && comp;
    r.has_ccb = ccb;
    r.needs_inflate = inflate;
    r.has_spec_header = pdh_ok && p_block == 0 && n >= DATA_OFF_LONG;
    want_q.push_back(r);

    // clear frame state for the next frame
    p_pos = '0;
    p_sum = '0;
    p_csum = '0;
    p_cmd = '0;
    p_stream = '0;
    p_fseq = '0;
    p_ttype = '0;
    p_block = '0;
    p_ctrl = '0;
    p_size = '0;
    p_pseq = '0;
    p_first = '0;
  endfunction

  // Build one frame and queue its words; cut > 0 forces the byte count
  task automatic add_frame(input logic [7:0] cmd, input logic [15:0] blk,
                           input logic [15:0] ctl, input logic [15:0] dbs_field,
                           input int data_cnt, input logic [7:0] ttype,
                           input logic [7:0] first, input bit bad_sum, input int cut);
    logic [7:0] fr[$];
    logic [15:0] sum;
    int off, len, i;
    in_word_t w;
    off = (blk == 0) ? DATA_OFF_LONG : DATA_OFF_SHORT;
    len = (cut > 0) ? cut : off + data_cnt;
    for (i = 0; i < off + data_cnt || i < len; i++) fr.push_back(8'($urandom_range(0, 255)));
    fr[POS_COMMAND] = cmd;
    fr[POS_TTYPE] = ttype;
    fr[POS_BLOCK_LO] = blk[15:8];
    fr[POS_BLOCK_HI] = blk[7:0];
    fr[POS_CTRL_LO] = ctl[15:8];
    fr[POS_CTRL_HI] = ctl[7:0];
    fr[POS_SIZE_LO] = dbs_field[15:8];
    fr[POS_SIZE_HI] = dbs_field[7:0];
    if (data_cnt > 0) fr[off] = first;
    sum = '0;
    for (i = 0; i < SUM_BYTES; i++) sum = sum + 16'(fr[i]);
    // any nonzero offset guarantees a mismatch
    if (bad_sum) sum = sum + 16'($urandom_range(1, 65535));
    fr[POS_CSUM_LO] = sum[15:8];
    fr[POS_CSUM_HI] = sum[7:0];
    for (i = 0; i < len; i++) begin
      w.data_byte = fr[i];
      w.last_byte = (i == len - 1);
      byte_q.push_back(w);
    end
    phase_bytes += len;
    phase_frames++;
  endtask

  // Mostly well-formed frames with random content, mixed with broken ones and noise
  task automatic add_random_frame();
    int kind, cnt, cut, i, len, d;
    logic [15:0] blk, ctl, dbs;
    logic [7:0] cmd, first;
    in_word_t w;
    kind = $urandom_range(0, 99);
    blk = ($urandom_range(0, 9) < 4) ? 16'h0 : 16'($urandom_range(1, 65535));
    cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
    case ($urandom_range(0, 3))
      0: ctl = '0;
      1: ctl = 16'($urandom_range(1, 40));
      2: ctl = 16'($urandom_range(0, cnt));
      default: ctl = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 1) == 0) first = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 1) == 0) first = 8'($urandom_range(8'h41, 8'h5A));
    else first = 8'($urandom_range(8'h61, 8'h7A));
    cmd = cur_cfg.data_transfer_command;
    dbs = 16'(cnt);
    cut = 0;
    if (kind >= 92) begin
      len = $urandom_range(1, 40);
      for (i = 0; i < len; i++) begin
        w.data_byte = 8'($urandom_range(0, 255));
        w.last_byte = (i == len - 1);
        byte_q.push_back(w);
      end
      phase_bytes += len;
      phase_frames++;
      return;
    end
    if (kind >= 82) begin
      cut = $urandom_range(1, 70);
    end else if (kind >= 72) begin
      d = $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 0) dbs = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 1) == 0) cut = ((blk == 0) ? DATA_OFF_LONG : DATA_OFF_SHORT) + cnt + d;
      else cut = ((blk == 0) ? DATA_OFF_LONG : DATA_OFF_SHORT) + cnt - d;
    end else if (kind >= 60) begin
      cmd = 8'($urandom_range(0, 255));
      cut = $urandom_range(16, 48);
    end
    add_frame(cmd, blk, ctl, dbs, cnt, 8'($urandom_range(0, 255)), first,
              $urandom_range(0, 9) == 0, cut);
  endtask

  // Write one register and track it
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DT_CMD:   cur_cfg.data_transfer_command = val;
      CFG_COMP_MSK: cur_cfg.compressed_mask = val;
      CFG_CCB_LEN:  cur_cfg.ccb_length = val;
      default:      cur_cfg.wmo_min_length = val;
    endcase
  endtask

  // Hold until every word is taken and every result has arrived
  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Stimulus: directed frames, then random frames under several settings
  initial begin
    int ph;
    logic [7:0] dtc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    dtc = RST_DT_CMD;
    add_frame(dtc, 0, 0, 8, 8, 8'h00, 8'h41, 0, 0);
    add_frame(dtc, 0, 0, 4, 4, 8'h02, 8'h00, 0, 0);
    add_frame(dtc, 0, 0, 30, 30, 8'h01, 8'h01, 0, 0);
    add_frame(dtc, 0, 0, 10, 10, 8'h00, 8'hFF, 0, 0);
    add_frame(dtc, 0, 20, 30, 30, 8'hFD, 8'h40, 0, 0);
    add_frame(dtc, 0, 24, 30, 30, 8'h00, 8'h7B, 0, 0);
    add_frame(dtc, 0, 10, 30, 30, 8'h00, 8'h5A, 0, 0);
    add_frame(dtc, 16'hFFFF, 40, 30, 30, 8'hFF, 8'h5B, 0, 0);
    add_frame(dtc, 5, 20, 20, 20, 8'h00, 8'h7A, 0, 0);
    add_frame(dtc, 0, 18, 18, 18, 8'h00, 8'h60, 0, 0);
    add_frame(dtc, 0, 18, 18, 18, 8'h00, 8'h61, 0, 0);
    add_frame(dtc, 1, 0, 0, 0, 8'h00, 8'h00, 1, 0);
    add_frame(8'hFF, 0, 0, 0, 0, 8'h00, 8'h00, 0, 16);
    add_frame(dtc, 0, 0, 0, 0, 8'h00, 8'h00, 0, 15);
    add_frame(dtc, 0, 0, 0, 0, 8'h00, 8'h00, 0, 1);
    add_frame(dtc, 0, 0, 0, 0, 8'h00, 8'h00, 0, 20);
    add_frame(dtc, 0, 0, 0, 0, 8'h00, 8'h00, 0, 40);
    add_frame(dtc, 0, 0, 16'hFFFF, 8, 8'h00, 8'h41, 0, 0);
    // block 0 frame ending right before its first data byte
    add_frame(dtc, 0, 0, 0, 0, 8'h00, 8'h00, 0, 0);
    add_frame(dtc, 0, 0, 0, 0, 8'h02, 8'h00, 0, 0);
    add_frame(dtc, 7, 0, 0, 0, 8'h00, 8'h00, 0, 0);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_DT_CMD, 8'h00);
          write_reg(CFG_COMP_MSK, 8'hFF);
          write_reg(CFG_CCB_LEN, 8'h00);
          write_reg(CFG_WMO_MIN, 8'h00);
        end
        2: begin
          write_reg(CFG_DT_CMD, 8'hFF);
          write_reg(CFG_COMP_MSK, 8'h00);
          write_reg(CFG_CCB_LEN, 8'hFF);
          write_reg(CFG_WMO_MIN, 8'hFF);
        end
        3: begin
          write_reg(CFG_DT_CMD, 8'($urandom_range(0, 255)));
          write_reg(CFG_COMP_MSK, 8'($urandom_range(0, 255)));
          write_reg(CFG_CCB_LEN, 8'($urandom_range(0, 48)));
          write_reg(CFG_WMO_MIN, 8'($urandom_range(0, 40)));
        end
        4: begin
          write_reg(CFG_DT_CMD, RST_DT_CMD);
          write_reg(CFG_COMP_MSK, RST_COMP_MSK);
          write_reg(CFG_CCB_LEN, RST_CCB_LEN);
          write_reg(CFG_WMO_MIN, RST_WMO_MIN);
          calm = 1'b1;
        end
        default: ;
      endcase
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) add_random_frame();
      wait_idle();
    end

    if (n_errors == 0 && want_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Sender: offer queued words, predict on acceptance, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_byte(in_data);
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_data <= byte_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver: stall in bursts, and twice for a long stretch to fill the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && n_results >= 12 + 8 * holds_done) begin
      holds_done++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      sink_gap = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (n_errors < 10)
        $display("result %0d field %s: expected %0h, got %0h", n_results, name, want, got);
      n_errors++;
    end
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results <= n_results + 1;
      if (want_q.size() == 0) begin
        if (n_errors < 10) $display("result %0d arrived with none expected: %p",
                                    n_results, out_data);
        n_errors++;
      end else begin
        oldest_want = want_q.pop_front();
        check_field("status", oldest_want.status, out_data.status);
        check_field("command", oldest_want.command, out_data.command);
        check_field("data_stream", oldest_want.data_stream, out_data.data_stream);
        check_field("frame_sequence", oldest_want.frame_sequence, out_data.frame_sequence);
        check_field("block_index", oldest_want.block_index, out_data.block_index);
        check_field("ctrl_length", oldest_want.ctrl_length, out_data.ctrl_length);
        check_field("payload_length", oldest_want.payload_length, out_data.payload_length);
        check_field("product_sequence", oldest_want.product_sequence,
                    out_data.product_sequence);
        check_field("is_compressed", oldest_want.is_compressed, out_data.is_compressed);
        check_field("has_ccb", oldest_want.has_ccb, out_data.has_ccb);
        check_field("needs_inflate", oldest_want.needs_inflate, out_data.needs_inflate);
        check_field("has_spec_header", oldest_want.has_spec_header, out_data.has_spec_header);
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

### filelist.f
rtl/core/sbnfhc_pkg.sv
rtl/core/sbnfhc_parse.sv
rtl/core/sbnfhc_queue.sv
rtl/core/sbnfhc_eval.sv
rtl/core/sbn_frame_header_checker.sv
test/tb_top.sv
